FILE: hdl/omk_pkg.sv
// Shared types and constants for the omni-wheel inverse kinematics block.
// No dependencies.
package omk_pkg;

    localparam int MAG_W = 64;             // exact Q.32 wheel speed magnitude
    localparam int LIM_W = 16;             // bits of the speed limit walked by the divider
    localparam int OUT_W = 13;             // wheel speed result width
    localparam int FIFO_DEPTH = 4;
    localparam int DEF_SPEED_LIMIT = 3000;

    localparam logic [2:0] REG_W0_COS   = 3'd0;
    localparam logic [2:0] REG_W0_SIN   = 3'd1;
    localparam logic [2:0] REG_W1_COS   = 3'd2;
    localparam logic [2:0] REG_W1_SIN   = 3'd3;
    localparam logic [2:0] REG_W2_COS   = 3'd4;
    localparam logic [2:0] REG_W2_SIN   = 3'd5;
    localparam logic [2:0] REG_ROT_GAIN = 3'd6;
    localparam logic [2:0] REG_SPD_GAIN = 3'd7;

    localparam logic signed [15:0] RST_W0_COS = -16'sd14189;
    localparam logic signed [15:0] RST_W0_SIN = 16'sd8192;
    localparam logic signed [15:0] RST_W1_COS = 16'sd0;
    localparam logic signed [15:0] RST_W1_SIN = -16'sd16384;
    localparam logic signed [15:0] RST_W2_COS = 16'sd14189;
    localparam logic signed [15:0] RST_W2_SIN = 16'sd8192;

    // One classified command on its way from front to back.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [MAG_W-1:0]      largest;
        logic                  scale;
    } omk_item_t;

endpackage

FILE: hdl/omk_front.sv
// Front end: config registers, wheel dot products, gain multiply, limit test.
// Depends on omk_pkg.
module omk_front #(
    parameter int SPEED_LIMIT = omk_pkg::DEF_SPEED_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_x_vel,
    input  logic signed [15:0]  s_y_vel,
    input  logic signed [15:0]  s_turn_rate,
    output logic                out_valid,
    input  logic                out_ready,
    output omk_pkg::omk_item_t  out_item
);
    import omk_pkg::*;

    logic signed [15:0] cos_reg [3];
    logic signed [15:0] sin_reg [3];
    logic [23:0]        rot_gain_reg;
    logic [23:0]        spd_gain_reg;

    logic [4:0]         vld_reg;
    logic               en;

    logic signed [31:0] px_reg [3];
    logic signed [31:0] py_reg [3];
    logic signed [40:0] pt_reg;
    logic [40:0]        a_reg [3];
    logic [2:0]         neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [47:0]        lo_reg [3];
    logic [40:0]        hi_reg [3];
    logic [MAG_W-1:0]   mag4_reg [3];
    logic [MAG_W-1:0]   mag5_reg [3];
    logic [MAG_W-1:0]   largest_reg;
    logic               scale_reg;

    logic signed [41:0] total [3];
    logic [MAG_W-1:0]   largest_next;
    logic               scale_next;

    localparam logic [MAG_W-1:0] LIM_Q32 = MAG_W'(SPEED_LIMIT) << 32;

    assign en = !vld_reg[4] || out_ready;
    assign s_ready = en;
    assign out_valid = vld_reg[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg[0] <= RST_W0_COS;
            sin_reg[0] <= RST_W0_SIN;
            cos_reg[1] <= RST_W1_COS;
            sin_reg[1] <= RST_W1_SIN;
            cos_reg[2] <= RST_W2_COS;
            sin_reg[2] <= RST_W2_SIN;
            rot_gain_reg <= '0;
            spd_gain_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_W0_COS:   cos_reg[0] <= cfg_wdata[15:0];
                REG_W0_SIN:   sin_reg[0] <= cfg_wdata[15:0];
                REG_W1_COS:   cos_reg[1] <= cfg_wdata[15:0];
                REG_W1_SIN:   sin_reg[1] <= cfg_wdata[15:0];
                REG_W2_COS:   cos_reg[2] <= cfg_wdata[15:0];
                REG_W2_SIN:   sin_reg[2] <= cfg_wdata[15:0];
                REG_ROT_GAIN: rot_gain_reg <= cfg_wdata;
                REG_SPD_GAIN: spd_gain_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], s_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // xy part is Q.14, times four brings it to Q.16
            total[i] = (42'(px_reg[i]) + 42'(py_reg[i])) * 42'sd4 + 42'(pt_reg);
        end
    end

    // largest of three plus the limit test, compared in parallel
    always_comb begin
        logic ge01, ge02, ge12;
        ge01 = mag4_reg[0] >= mag4_reg[1];
        ge02 = mag4_reg[0] >= mag4_reg[2];
        ge12 = mag4_reg[1] >= mag4_reg[2];
        if (ge01 && ge02) begin
            largest_next = mag4_reg[0];
        end else if (ge12) begin
            largest_next = mag4_reg[1];
        end else begin
            largest_next = mag4_reg[2];
        end
        scale_next = (mag4_reg[0] > LIM_Q32) || (mag4_reg[1] > LIM_Q32)
                     || (mag4_reg[2] > LIM_Q32);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                px_reg[i] <= cos_reg[i] * s_x_vel;
                py_reg[i] <= sin_reg[i] * s_y_vel;
                neg2_reg[i] <= total[i][41];
                a_reg[i] <= total[i][41] ? 41'(-total[i]) : total[i][40:0];
                lo_reg[i] <= 48'(a_reg[i][23:0]) * 48'(spd_gain_reg);
                hi_reg[i] <= 41'(a_reg[i][40:24]) * 41'(spd_gain_reg);
                mag4_reg[i] <= MAG_W'(lo_reg[i]) + (MAG_W'(hi_reg[i]) << 24);
                mag5_reg[i] <= mag4_reg[i];
            end
            pt_reg <= $signed({1'b0, rot_gain_reg}) * s_turn_rate;
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            largest_reg <= largest_next;
            scale_reg <= scale_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_item.mag[i] = mag5_reg[i];
        end
        out_item.neg = neg5_reg;
        out_item.largest = largest_reg;
        out_item.scale = scale_reg;
    end

endmodule

FILE: hdl/omk_fifo.sv
// Short queue between front and back ends.
// Depends on omk_pkg.
module omk_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  omk_pkg::omk_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output omk_pkg::omk_item_t pop_item
);
    import omk_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    omk_item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic                 push, pop;

    assign push_ready = count_reg != (PTR_W+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == (PTR_W+1)'(FIFO_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

FILE: hdl/omk_scale.sv
// One wheel's scaling lane: pipelined exact m*limit/largest, rounding, clamp.
// Depends on omk_pkg.
module omk_scale #(
    parameter int SPEED_LIMIT = omk_pkg::DEF_SPEED_LIMIT
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [omk_pkg::MAG_W-1:0]     m_in,
    input  logic [omk_pkg::MAG_W-1:0]     d_in,
    input  logic                          scale_in,
    input  logic                          neg_in,
    output logic signed [omk_pkg::OUT_W-1:0] res
);
    import omk_pkg::*;

    localparam int NS = 2 * LIM_W;
    localparam logic [LIM_W-1:0] LIM = LIM_W'(SPEED_LIMIT);

    logic [MAG_W-1:0] r_reg [NS];
    logic [LIM_W-1:0] q_reg [NS];
    logic [MAG_W-1:0] m_reg [NS];
    logic [MAG_W-1:0] d_reg [NS];
    logic             sc_reg [NS];
    logic             ng_reg [NS];
    logic signed [OUT_W-1:0] res_reg;

    // stage 2k doubles the remainder, stage 2k+1 adds m when the limit bit is set
    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [MAG_W-1:0] r_in, m_s, d_s, r_out;
        logic [LIM_W-1:0] q_in, q_out;
        logic             sc_s, ng_s, take;
        if (k == 0) begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign m_s  = m_in;
            assign d_s  = d_in;
            assign sc_s = scale_in;
            assign ng_s = neg_in;
        end else begin : g_next
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            assign m_s  = m_reg[k-1];
            assign d_s  = d_reg[k-1];
            assign sc_s = sc_reg[k-1];
            assign ng_s = ng_reg[k-1];
        end
        if (k % 2 == 0) begin : g_dbl
            assign take  = r_in >= d_s - r_in;
            assign r_out = take ? r_in - (d_s - r_in) : r_in + r_in;
            assign q_out = {q_in[LIM_W-2:0], take};
        end else if (LIM[LIM_W-1-k/2]) begin : g_add
            assign take  = r_in >= d_s - m_s;
            assign r_out = take ? r_in - (d_s - m_s) : r_in + m_s;
            assign q_out = q_in + LIM_W'(take);
        end else begin : g_pass
            assign take  = 1'b0;
            assign r_out = r_in;
            assign q_out = q_in;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]  <= r_out;
                q_reg[k]  <= q_out;
                m_reg[k]  <= m_s;
                d_reg[k]  <= d_s;
                sc_reg[k] <= sc_s;
                ng_reg[k] <= ng_s;
            end
        end
    end

    logic [32:0] q_fin, q_sat, q_cap;
    logic [MAG_W:0] m_rnd;
    logic [LIM_W:0] q_div;

    always_comb begin
        q_div = {1'b0, q_reg[NS-1]}
                + (LIM_W+1)'(r_reg[NS-1] >= d_reg[NS-1] - r_reg[NS-1]);
        m_rnd = {1'b0, m_reg[NS-1]} + (MAG_W+1)'(64'h8000_0000);
        q_fin = sc_reg[NS-1] ? 33'(q_div) : m_rnd[MAG_W:32];
        q_cap = ng_reg[NS-1] ? 33'd4096 : 33'd4095;
        q_sat = (q_fin > q_cap) ? q_cap : q_fin;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= ng_reg[NS-1] ? -$signed(q_sat[OUT_W-1:0])
                                    : $signed(q_sat[OUT_W-1:0]);
        end
    end

    assign res = res_reg;

endmodule

FILE: hdl/omk_back.sv
// Back end: three scaling lanes, valid tracking and the result register.
// Depends on omk_pkg and omk_scale.
module omk_back #(
    parameter int SPEED_LIMIT = omk_pkg::DEF_SPEED_LIMIT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  omk_pkg::omk_item_t            in_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [omk_pkg::OUT_W-1:0] m_left_speed,
    output logic signed [omk_pkg::OUT_W-1:0] m_back_speed,
    output logic signed [omk_pkg::OUT_W-1:0] m_right_speed
);
    import omk_pkg::*;

    localparam int NS = 2 * LIM_W;

    logic [NS:0]             vld_reg;
    logic                    en;
    logic signed [OUT_W-1:0] res [3];

    assign en = !vld_reg[NS] || m_ready;
    assign in_ready = en;
    assign m_valid = vld_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        omk_scale #(.SPEED_LIMIT(SPEED_LIMIT)) u_scale (
            .aclk     (aclk),
            .en       (en),
            .m_in     (in_item.mag[i]),
            .d_in     (in_item.largest),
            .scale_in (in_item.scale),
            .neg_in   (in_item.neg[i]),
            .res      (res[i])
        );
    end

    assign m_left_speed  = res[0];
    assign m_back_speed  = res[1];
    assign m_right_speed = res[2];

endmodule

FILE: hdl/omniwheel_inverse_kinematics_top.sv
// Top level of the three-wheel omni drive inverse kinematics block.
// Depends on omk_pkg, omk_front, omk_fifo, omk_back.
//
// Turns a body velocity command into three wheel speeds. One command is
// accepted per clock cycle while s_ready is high, and results come out
// in order, one per command. The front is pipelined through products,
// sum, split gain multiply and largest/limit test; in the back, after
// the queue, each wheel runs a pipelined restoring divider of at most
// one compare-subtract per stage to scale by limit/largest when the limit
// is exceeded. The queue lets the front keep taking commands while the
// result port is stalled, until it fills. Coefficient writes take effect
// for commands accepted afterwards; write only while the block is idle.
module omniwheel_inverse_kinematics_top #(
    parameter int SPEED_LIMIT = omk_pkg::DEF_SPEED_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_x_vel,
    input  logic signed [15:0]  s_y_vel,
    input  logic signed [15:0]  s_turn_rate,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [12:0]  m_left_speed,
    output logic signed [12:0]  m_back_speed,
    output logic signed [12:0]  m_right_speed
);
    import omk_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    omk_item_t f_item, b_item;

    omk_front #(.SPEED_LIMIT(SPEED_LIMIT)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_vel     (s_x_vel),
        .s_y_vel     (s_y_vel),
        .s_turn_rate (s_turn_rate),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_item    (f_item)
    );

    omk_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    omk_back #(.SPEED_LIMIT(SPEED_LIMIT)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (b_valid),
        .in_ready      (b_ready),
        .in_item       (b_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_speed  (m_left_speed),
        .m_back_speed  (m_back_speed),
        .m_right_speed (m_right_speed)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for omniwheel_inverse_kinematics_top.
// Depends on omk_pkg and the block's RTL; predicts wheel speeds in exact integer maths.
module tb_top;
    import omk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = DEF_SPEED_LIMIT;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 60;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_x_vel;
    logic signed [15:0] s_y_vel;
    logic signed [15:0] s_turn_rate;
    logic               m_valid;
    logic               m_ready;
    logic signed [12:0] m_left_speed;
    logic signed [12:0] m_back_speed;
    logic signed [12:0] m_right_speed;

    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] back;
        logic signed [12:0] right;
    } wheel_speeds_t;

    wheel_speeds_t speeds_due[$];

    logic signed [15:0] coef_cos[3];
    logic signed [15:0] coef_sin[3];
    logic [23:0]        gain_rot;
    logic [23:0]        gain_spd;

    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  quiet_cycles;

    omniwheel_inverse_kinematics_top u_top (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // round(m*lim/d) half away from zero, m <= d
    function automatic logic [15:0] scale_to_limit(input logic [63:0] m,
                                                   input logic [63:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        num = 128'(m) * 128'(LIMIT);
        q = num / 128'(d);
        r = num % 128'(d);
        if (r >= 128'(d) - r)
            q++;
        return q[15:0];
    endfunction

    function automatic wheel_speeds_t predict_speeds(input logic signed [15:0] x,
                                                     input logic signed [15:0] y,
                                                     input logic signed [15:0] t);
        logic [63:0]          mag[3];
        bit                   neg[3];
        logic [63:0]          largest;
        longint               total;
        longint               q;
        longint               v;
        longint               res[3];
        wheel_speeds_t        s;
        largest = 0;
        for (int i = 0; i < 3; i++) begin
            total = (longint'(coef_cos[i]) * x + longint'(coef_sin[i]) * y) * 4
                    + longint'({1'b0, gain_rot}) * t;
            neg[i] = total < 0;
            mag[i] = (neg[i] ? -total : total) * longint'({1'b0, gain_spd});
            if (mag[i] > largest)
                largest = mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (largest > (64'(LIMIT) << 32))
                q = scale_to_limit(mag[i], largest);
            else
                q = longint'((mag[i] + 64'h8000_0000) >> 32);
            v = neg[i] ? -q : q;
            if (v > 4095)
                v = 4095;
            if (v < -4096)
                v = -4096;
            res[i] = v;
        end
        s.left  = 13'(res[0]);
        s.back  = 13'(res[1]);
        s.right = 13'(res[2]);
        return s;
    endfunction

    // write enable stays high across back-to-back writes; callers drop it
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_W0_COS:   coef_cos[0] = val[15:0];
            REG_W0_SIN:   coef_sin[0] = val[15:0];
            REG_W1_COS:   coef_cos[1] = val[15:0];
            REG_W1_SIN:   coef_sin[1] = val[15:0];
            REG_W2_COS:   coef_cos[2] = val[15:0];
            REG_W2_SIN:   coef_sin[2] = val[15:0];
            REG_ROT_GAIN: gain_rot = val;
            REG_SPD_GAIN: gain_spd = val;
            default: ;
        endcase
    endtask

    // valid is left high after a transfer so the next item can follow at once
    task automatic send_command(input logic signed [15:0] x,
                                input logic signed [15:0] y,
                                input logic signed [15:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_x_vel     <= x;
        s_y_vel     <= y;
        s_turn_rate <= t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        speeds_due.push_back(predict_speeds(x, y, t));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (speeds_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_all(input logic signed [15:0] c0, input logic signed [15:0] s0,
                             input logic signed [15:0] c1, input logic signed [15:0] s1,
                             input logic signed [15:0] c2, input logic signed [15:0] s2,
                             input logic [23:0] rg, input logic [23:0] sg);
        write_reg(REG_W0_COS, 24'(c0));
        write_reg(REG_W0_SIN, 24'(s0));
        write_reg(REG_W1_COS, 24'(c1));
        write_reg(REG_W1_SIN, 24'(s1));
        write_reg(REG_W2_COS, 24'(c2));
        write_reg(REG_W2_SIN, 24'(s2));
        write_reg(REG_ROT_GAIN, rg);
        write_reg(REG_SPD_GAIN, sg);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coef();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    task automatic test_directed();
        // nominal geometry, modest gains; zero command, extremes, limit edge
        write_all(RST_W0_COS, RST_W0_SIN, RST_W1_COS, RST_W1_SIN, RST_W2_COS,
                  RST_W2_SIN, 24'h00_4000, 24'h01_0000);
        send_command(16'sd0, 16'sd0, 16'sd0);
        send_command(16'sd32767, 16'sd0, 16'sd0);
        send_command(-16'sd32768, 16'sd0, 16'sd0);
        send_command(16'sd0, 16'sd32767, 16'sd0);
        send_command(16'sd0, -16'sd32768, 16'sd0);
        send_command(16'sd0, 16'sd0, 16'sd32767);
        send_command(16'sd0, 16'sd0, -16'sd32768);
        send_command(-16'sd32768, -16'sd32768, -16'sd32768);
        send_command(16'sd32767, 16'sd32767, 16'sd32767);
        send_command(16'sd3000, 16'sd0, 16'sd0);   // back wheel exactly zero
        send_command(16'sd0, -16'sd3000, 16'sd0);  // largest exactly at the limit
        send_command(16'sd0, -16'sd3001, 16'sd0);  // just over: scaled
        wait_drained();
        // extreme gains and coefficients
        write_all(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384,
                  16'sd16384, 24'hFF_FFFF, 24'hFF_FFFF);
        send_command(-16'sd32768, 16'sd32767, -16'sd32768);
        send_command(16'sd1, 16'sd0, 16'sd0);
        send_command(16'sd0, 16'sd0, 16'sd1);
        send_command(16'sd32767, -16'sd32768, 16'sd32767);
        wait_drained();
        // tiny gain: rounding half away from zero
        write_all(16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd1, -16'sd1,
                  24'h00_0001, 24'h00_8000);
        send_command(16'sd1, 16'sd1, 16'sd1);
        send_command(-16'sd1, -16'sd1, -16'sd1);
        send_command(16'sd12345, -16'sd321, 16'sd77);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] t;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                wait_drained();
                for (int i = 0; i < 8; i++)
                    write_reg(3'(i), ($urandom_range(3) == 0) ? 24'($urandom())
                        : (i < 6 ? 24'(rand_coef()) : 24'($urandom_range(24'h03_0000))));
                cfg_we <= 1'b0;
            end
            case ($urandom_range(3))
                0: begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                    t = 16'($urandom());
                end
                default: begin
                    x = 16'($urandom_range(4000) - 2000);
                    y = 16'($urandom_range(4000) - 2000);
                    t = 16'($urandom_range(400) - 200);
                end
            endcase
            send_command(x, y, t);
        end
    endtask

    task automatic test_backpressure();
        // hold the result side so the queue fills and s_ready drops
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            test_random(60);
        join
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_command(16'($urandom()), 16'($urandom()), 16'($urandom()));
        wait_drained();
    endtask

    // result side: ready and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (speeds_due.size() == 0) begin
                    report_mismatch("unexpected result", m_left_speed, 0);
                end else begin
                    wheel_speeds_t want;
                    want = speeds_due.pop_front();
                    if (m_left_speed !== want.left)
                        report_mismatch("left_speed", m_left_speed, want.left);
                    if (m_back_speed !== want.back)
                        report_mismatch("back_speed", m_back_speed, want.back);
                    if (m_right_speed !== want.right)
                        report_mismatch("right_speed", m_right_speed, want.right);
                end
            end
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_x_vel      = '0;
        s_y_vel      = '0;
        s_turn_rate  = '0;
        m_ready      = 1'b0;
        recv_hold    = 1'b0;
        quiet_cycles = 0;
        error_count  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 83;
        coef_cos = '{RST_W0_COS, RST_W1_COS, RST_W2_COS};
        coef_sin = '{RST_W0_SIN, RST_W1_SIN, RST_W2_SIN};
        gain_rot = '0;
        gain_spd = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset gains are zero: everything must come out zero
        send_command(16'sd1000, -16'sd1000, 16'sd50);
        wait_drained();
        test_directed();
        test_random(400);
        send_idle_pct = 83;
        recv_idle_pct = 22;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        test_backpressure();
        wait_drained();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
